FILE: rtl/rgb_histogram_matching_core_defines.svh
// Assertion macros shared by the histogram matching RTL.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef RGB_HISTOGRAM_MATCHING_CORE_DEFINES_SVH
`define RGB_HISTOGRAM_MATCHING_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RHM_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rhm check failed");

// The consequent must hold in the cycle after the antecedent.
`define RHM_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rhm check failed");

`endif

FILE: rtl/rhm_pkg.sv
// Package for the RGB histogram matching core: sizes, mode codes, bank command types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rhm_pkg;

   localparam int CHANNELS   = 3;
   localparam int COUNT_BITS = 20;
   localparam int LEVELS     = 256;
   localparam int PIX_BITS   = 8;
   localparam int LEVEL_BITS = $clog2(LEVELS);
   localparam int PTR_BITS   = LEVEL_BITS + 1;
   localparam int CDF_BITS   = COUNT_BITS + LEVEL_BITS;
   localparam int CH_BITS    = 2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [LEVEL_BITS-1:0] LAST_LEVEL = LEVEL_BITS'(LEVELS - 1);
   localparam logic [PTR_BITS-1:0]   PTR_END = PTR_BITS'(LEVELS);
   localparam logic [CH_BITS-1:0]    LAST_CH = CH_BITS'(CHANNELS - 1);

   typedef enum logic [1:0] {
      MODE_REF   = 2'd0,
      MODE_SRC   = 2'd1,
      MODE_BUILD = 2'd2,
      MODE_MAP   = 2'd3
   } mode_type;

   // Command to one channel bank.
   typedef struct packed {
      logic                  hist_rd;
      logic [LEVEL_BITS-1:0] hist_rd_addr;
      logic                  ref_we;
      logic                  src_we;
      logic [LEVEL_BITS-1:0] hist_wr_addr;
      logic [COUNT_BITS-1:0] ref_wdata;
      logic [COUNT_BITS-1:0] src_wdata;
      logic                  lut_rd;
      logic                  lut_we;
      logic [LEVEL_BITS-1:0] lut_addr;
      logic [PIX_BITS-1:0]   lut_wdata;
   } bank_cmd_type;

   // Registered read data from one channel bank.
   typedef struct packed {
      logic [COUNT_BITS-1:0] ref_q;
      logic [COUNT_BITS-1:0] src_q;
      logic [PIX_BITS-1:0]   lut_q;
   } bank_rsp_type;

   // Levels at or above LEVELS count as the top level.
   function automatic logic [LEVEL_BITS-1:0] clamp_level(input logic [PIX_BITS-1:0] v);
      logic [PIX_BITS:0] wide;
      wide = {1'b0, v};
      if (wide >= (PIX_BITS+1)'(LEVELS)) begin
         return LAST_LEVEL;
      end
      return v[LEVEL_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/rhm_ifs.sv
// Valid/ready channel interfaces for pixel requests and mapped pixel responses.
// Depends on rhm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface rhm_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   mode;
   logic [rhm_pkg::PIX_BITS-1:0] red_in;
   logic [rhm_pkg::PIX_BITS-1:0] green_in;
   logic [rhm_pkg::PIX_BITS-1:0] blue_in;
   modport source (output valid, mode, red_in, green_in, blue_in, input ready);
   modport sink (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface

interface rhm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rhm_pkg::PIX_BITS-1:0] red_out;
   logic [rhm_pkg::PIX_BITS-1:0] green_out;
   logic [rhm_pkg::PIX_BITS-1:0] blue_out;
   logic                         counts_saturated;
   modport source (output valid, red_out, green_out, blue_out, counts_saturated,
                   input ready);
   modport sink (input valid, red_out, green_out, blue_out, counts_saturated,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/rhm_bank.sv
// One color channel's storage: reference and source histograms and the level table.
// Depends on rhm_pkg for the command and read data types.
`timescale 1ns / 1ps
`default_nettype none
module rhm_bank (
   input  wire logic                  clock,
   input  wire rhm_pkg::bank_cmd_type cmd,
   output rhm_pkg::bank_rsp_type      rsp
);

   logic [rhm_pkg::COUNT_BITS-1:0] ref_mem [rhm_pkg::LEVELS];
   logic [rhm_pkg::COUNT_BITS-1:0] src_mem [rhm_pkg::LEVELS];
   logic [rhm_pkg::PIX_BITS-1:0]   lut_mem [rhm_pkg::LEVELS];

   logic [rhm_pkg::COUNT_BITS-1:0] ref_q_ff;
   logic [rhm_pkg::COUNT_BITS-1:0] src_q_ff;
   logic [rhm_pkg::PIX_BITS-1:0]   lut_q_ff;

   // Histogram pair: one read port and one write port, read data held until the next read.
   always_ff @(posedge clock) begin
      if (cmd.hist_rd) begin
         ref_q_ff <= ref_mem[cmd.hist_rd_addr];
         src_q_ff <= src_mem[cmd.hist_rd_addr];
      end
      if (cmd.ref_we) begin
         ref_mem[cmd.hist_wr_addr] <= cmd.ref_wdata;
      end
      if (cmd.src_we) begin
         src_mem[cmd.hist_wr_addr] <= cmd.src_wdata;
      end
   end

   // Level table: single port, read or write.
   always_ff @(posedge clock) begin
      if (cmd.lut_we) begin
         lut_mem[cmd.lut_addr] <= cmd.lut_wdata;
      end
      if (cmd.lut_rd) begin
         lut_q_ff <= lut_mem[cmd.lut_addr];
      end
   end

   assign rsp.ref_q = ref_q_ff;
   assign rsp.src_q = src_q_ff;
   assign rsp.lut_q = lut_q_ff;

endmodule
`default_nettype wire

FILE: rtl/rhm_seq.sv
// Sequencer: pixel counting, table build (cumulative sums and nearest match), mapping.
// Depends on rhm_pkg, rhm_ifs and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "rgb_histogram_matching_core_defines.svh"
module rhm_seq (
   input  wire logic                  clock,
   input  wire logic                  reset,
   rhm_req_if.sink                    req_ch,
   rhm_rsp_if.source                  rsp_ch,
   output rhm_pkg::bank_cmd_type      cmd [rhm_pkg::CHANNELS],
   input  wire rhm_pkg::bank_rsp_type bank_q [rhm_pkg::CHANNELS]
);

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_COUNT  = 8'b0000_0100,
      S_MAP    = 8'b0000_1000,
      S_SUM_RD = 8'b0001_0000,
      S_SUM_WR = 8'b0010_0000,
      S_M_RD   = 8'b0100_0000,
      S_M_EVAL = 8'b1000_0000
   } state_type;

   localparam int LB = rhm_pkg::LEVEL_BITS;
   localparam int CB = rhm_pkg::CDF_BITS;

   state_type state_ff, state_in;
   rhm_pkg::mode_type mode_ff, mode_in;
   logic [LB-1:0] lvl_ff [rhm_pkg::CHANNELS];
   logic [LB-1:0] lvl_in [rhm_pkg::CHANNELS];
   logic [rhm_pkg::CH_BITS-1:0] ch_ff, ch_in;
   logic [LB-1:0] idx_ff, idx_in;
   logic [rhm_pkg::PTR_BITS-1:0] k_ff, k_in;
   logic [LB-1:0] p_ff, p_in;
   logic [CB-1:0] prev_ff, prev_in;
   logic [CB-1:0] acc_r_ff, acc_r_in;
   logic [CB-1:0] acc_s_ff, acc_s_in;
   logic sat_acc_ff, sat_acc_in;
   logic sat_flag_ff, sat_flag_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [rhm_pkg::PIX_BITS-1:0] rsp_pix_ff [rhm_pkg::CHANNELS];
   logic rsp_sat_ff;
   logic rsp_load;

   // Cumulative sums of the channel being built.
   logic [CB-1:0] cdf_ref_mem [rhm_pkg::LEVELS];
   logic [CB-1:0] cdf_src_mem [rhm_pkg::LEVELS];
   logic [CB-1:0] cr_q_ff;
   logic [CB-1:0] cs_q_ff;

   logic [rhm_pkg::COUNT_BITS-1:0] sel_ref_q;
   logic [rhm_pkg::COUNT_BITS-1:0] sel_src_q;
   logic advance;
   logic [LB-1:0] choice;

   // Histogram read data of the channel being built.
   always_comb begin
      sel_ref_q = '0;
      sel_src_q = '0;
      for (int c = 0; c < rhm_pkg::CHANNELS; c++) begin
         if (ch_ff == rhm_pkg::CH_BITS'(c)) begin
            sel_ref_q = bank_q[c].ref_q;
            sel_src_q = bank_q[c].src_q;
         end
      end
   end

   // Nearest reference level: the pointer stops at the first level above the source sum.
   always_comb begin
      advance = (k_ff != rhm_pkg::PTR_END) && (cr_q_ff <= cs_q_ff);
      if (k_ff == '0) begin
         choice = '0;
      end else if (k_ff == rhm_pkg::PTR_END) begin
         choice = p_ff;
      end else if ((cs_q_ff - prev_ff) <= (cr_q_ff - cs_q_ff)) begin
         choice = p_ff;
      end else begin
         choice = k_ff[LB-1:0];
      end
   end

   assign rsp_load = !rsp_valid_ff || rsp_ch.ready;

   // Main control.
   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      lvl_in      = lvl_ff;
      ch_in       = ch_ff;
      idx_in      = idx_ff;
      k_in        = k_ff;
      p_in        = p_ff;
      prev_in     = prev_ff;
      acc_r_in    = acc_r_ff;
      acc_s_in    = acc_s_ff;
      sat_acc_in  = sat_acc_ff;
      sat_flag_in = sat_flag_ff;
      for (int c = 0; c < rhm_pkg::CHANNELS; c++) begin
         cmd[c] = '0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            for (int c = 0; c < rhm_pkg::CHANNELS; c++) begin
               cmd[c].ref_we       = 1'b1;
               cmd[c].src_we       = 1'b1;
               cmd[c].hist_wr_addr = idx_ff;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == rhm_pkg::LAST_LEVEL) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               mode_in   = rhm_pkg::mode_type'(req_ch.mode);
               lvl_in[0] = rhm_pkg::clamp_level(req_ch.red_in);
               lvl_in[1] = rhm_pkg::clamp_level(req_ch.green_in);
               lvl_in[2] = rhm_pkg::clamp_level(req_ch.blue_in);
               unique case (rhm_pkg::mode_type'(req_ch.mode)) inside
                  rhm_pkg::MODE_REF, rhm_pkg::MODE_SRC: begin
                     for (int c = 0; c < rhm_pkg::CHANNELS; c++) begin
                        cmd[c].hist_rd      = 1'b1;
                        cmd[c].hist_rd_addr = lvl_in[c];
                     end
                     state_in = S_COUNT;
                  end
                  rhm_pkg::MODE_BUILD: begin
                     ch_in      = '0;
                     idx_in     = '0;
                     acc_r_in   = '0;
                     acc_s_in   = '0;
                     sat_acc_in = 1'b0;
                     state_in   = S_SUM_RD;
                  end
                  default: begin
                     for (int c = 0; c < rhm_pkg::CHANNELS; c++) begin
                        cmd[c].lut_rd   = 1'b1;
                        cmd[c].lut_addr = lvl_in[c];
                     end
                     state_in = S_MAP;
                  end
               endcase
            end
         end
         S_COUNT: begin
            // Saturating increment written back to the bin read last cycle.
            for (int c = 0; c < rhm_pkg::CHANNELS; c++) begin
               cmd[c].ref_we       = (mode_ff == rhm_pkg::MODE_REF);
               cmd[c].src_we       = (mode_ff == rhm_pkg::MODE_SRC);
               cmd[c].hist_wr_addr = lvl_ff[c];
               cmd[c].ref_wdata    = (bank_q[c].ref_q == rhm_pkg::COUNT_MAX) ?
                  bank_q[c].ref_q : rhm_pkg::COUNT_BITS'(bank_q[c].ref_q + 1'b1);
               cmd[c].src_wdata    = (bank_q[c].src_q == rhm_pkg::COUNT_MAX) ?
                  bank_q[c].src_q : rhm_pkg::COUNT_BITS'(bank_q[c].src_q + 1'b1);
            end
            state_in = S_IDLE;
         end
         S_MAP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         S_SUM_RD: begin
            for (int c = 0; c < rhm_pkg::CHANNELS; c++) begin
               if (ch_ff == rhm_pkg::CH_BITS'(c)) begin
                  cmd[c].hist_rd      = 1'b1;
                  cmd[c].hist_rd_addr = idx_ff;
               end
            end
            state_in = S_SUM_WR;
         end
         S_SUM_WR: begin
            // Accumulate, then clear the bin just consumed.
            acc_r_in = acc_r_ff + CB'(sel_ref_q);
            acc_s_in = acc_s_ff + CB'(sel_src_q);
            if (sel_ref_q == rhm_pkg::COUNT_MAX || sel_src_q == rhm_pkg::COUNT_MAX) begin
               sat_acc_in = 1'b1;
            end
            for (int c = 0; c < rhm_pkg::CHANNELS; c++) begin
               if (ch_ff == rhm_pkg::CH_BITS'(c)) begin
                  cmd[c].ref_we       = 1'b1;
                  cmd[c].src_we       = 1'b1;
                  cmd[c].hist_wr_addr = idx_ff;
               end
            end
            if (idx_ff == rhm_pkg::LAST_LEVEL) begin
               idx_in   = '0;
               k_in     = '0;
               p_in     = '0;
               prev_in  = '0;
               state_in = S_M_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SUM_RD;
            end
         end
         S_M_RD: begin
            state_in = S_M_EVAL;
         end
         S_M_EVAL: begin
            if (advance) begin
               // A new run of equal sums starts here: remember its first level.
               if (k_ff == '0 || cr_q_ff != prev_ff) begin
                  p_in = k_ff[LB-1:0];
               end
               prev_in  = cr_q_ff;
               k_in     = k_ff + 1'b1;
               state_in = S_M_RD;
            end else begin
               for (int c = 0; c < rhm_pkg::CHANNELS; c++) begin
                  if (ch_ff == rhm_pkg::CH_BITS'(c)) begin
                     cmd[c].lut_we    = 1'b1;
                     cmd[c].lut_addr  = idx_ff;
                     cmd[c].lut_wdata = rhm_pkg::PIX_BITS'(choice);
                  end
               end
               if (idx_ff != rhm_pkg::LAST_LEVEL) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_M_RD;
               end else if (ch_ff == rhm_pkg::LAST_CH) begin
                  sat_flag_in = sat_acc_ff;
                  state_in    = S_IDLE;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  idx_in   = '0;
                  acc_r_in = '0;
                  acc_s_in = '0;
                  state_in = S_SUM_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Response register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == S_MAP && rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         sat_flag_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
         sat_flag_ff  <= sat_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      lvl_ff     <= lvl_in;
      ch_ff      <= ch_in;
      p_ff       <= p_in;
      prev_ff    <= prev_in;
      acc_r_ff   <= acc_r_in;
      acc_s_ff   <= acc_s_in;
      sat_acc_ff <= sat_acc_in;
      if (state_ff == S_MAP && rsp_load) begin
         for (int c = 0; c < rhm_pkg::CHANNELS; c++) begin
            rsp_pix_ff[c] <= bank_q[c].lut_q;
         end
         rsp_sat_ff <= sat_flag_ff;
      end
   end

   // Cumulative sum memories: written during the sum sweep, read during the search.
   always_ff @(posedge clock) begin
      if (state_ff == S_SUM_WR) begin
         cdf_ref_mem[idx_ff] <= acc_r_in;
         cdf_src_mem[idx_ff] <= acc_s_in;
      end
      if (state_ff == S_M_RD) begin
         cs_q_ff <= cdf_src_mem[idx_ff];
         if (k_ff != rhm_pkg::PTR_END) begin
            cr_q_ff <= cdf_ref_mem[k_ff[LB-1:0]];
         end
      end
   end

   assign req_ch.ready            = (state_ff == S_IDLE);
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.red_out          = rsp_pix_ff[0];
   assign rsp_ch.green_out        = rsp_pix_ff[1];
   assign rsp_ch.blue_out         = rsp_pix_ff[2];
   assign rsp_ch.counts_saturated = rsp_sat_ff;

   `RHM_ASSERT_SAME(a_ptr_range, 1'b1, k_ff <= rhm_pkg::PTR_END)
   `RHM_ASSERT_NEXT(a_count_one_beat, state_ff == S_COUNT, state_ff == S_IDLE)
   `RHM_ASSERT_NEXT(a_map_loads_rsp, state_ff == S_MAP && rsp_load, rsp_valid_ff)

endmodule
`default_nettype wire

FILE: rtl/rgb_histogram_matching_core.sv
// Top level of the RGB histogram matching core: sequencer and three channel banks.
// Depends on rhm_pkg, rhm_ifs, rhm_bank and rhm_seq.
`timescale 1ns / 1ps
`default_nettype none
// Per-channel histogram specification for 8-bit RGB pixels. Mode 0 beats count a
// reference pixel and mode 1 beats a source pixel, each by a histogram read followed
// by the write back of the saturating count. Mode 3 maps a pixel through the level
// table and returns one response beat; a mode 3 beat waits only if the previous
// response has not been taken. Mode 2 builds the tables: per channel, a sum sweep
// that also clears the histograms, then a nearest-level search whose pointer only
// moves forward. After reset the block clears its histograms before it accepts its
// first beat. Mapping before any build returns undefined levels.
module rgb_histogram_matching_core (
   input  wire logic clock,
   input  wire logic reset,
   rhm_req_if.sink   req_ch,
   rhm_rsp_if.source rsp_ch
);

   rhm_pkg::bank_cmd_type cmd [rhm_pkg::CHANNELS];
   rhm_pkg::bank_rsp_type bank_q [rhm_pkg::CHANNELS];

   rhm_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .cmd    (cmd),
      .bank_q (bank_q)
   );

   // One storage bank per color channel.
   for (genvar c = 0; c < rhm_pkg::CHANNELS; c++) begin : g_bank
      rhm_bank u_bank (
         .clock (clock),
         .cmd   (cmd[c]),
         .rsp   (bank_q[c])
      );
   end

endmodule
`default_nettype wire
